// ----- hw/rtl/wpta_pkg.sv -----
// ----------------------------------------------------------------------------
// wpta_pkg
// shared constants and types of the windowed peak/trough averager
// ----------------------------------------------------------------------------
`default_nettype none

package wpta_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int WLEN_BITS       = 16;
	localparam int WIDX_BITS       = 3;
	localparam int PEAK_OUT_BITS   = 12;
	localparam int TROUGH_OUT_BITS = 13;
	localparam int TROUGH_INIT     = 4096;
	localparam int WINDOWS_SUMMED  = 5;

	localparam logic [WLEN_BITS-1:0] WLEN_RESET = 16'd200;

	typedef struct packed {
		logic close;
		logic emit;
	} wpta_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wpta_div5.sv -----
// ----------------------------------------------------------------------------
// wpta_div5
// truncated division by five through a reciprocal multiply and one correction
// ----------------------------------------------------------------------------
`default_nettype none

module wpta_div5 #(
	parameter int DW = 16
) (
	input  wire logic [DW-1:0] num,
	output logic      [DW-1:0] quot
);
	import wpta_pkg::*;

	localparam int K = DW + 2;
	localparam logic [K-1:0] RECIP = K'((64'd1 << K) / WINDOWS_SUMMED);
	localparam logic [DW+2:0] FIVE = (DW+3)'(WINDOWS_SUMMED);

	logic [DW+K-1:0] prod;
	logic [DW-1:0]   q0;
	logic [DW+2:0]   q0_x5;
	logic [DW+2:0]   rem;

	assign prod  = {{K{1'b0}}, num} * {{DW{1'b0}}, RECIP};
	assign q0    = prod[DW+K-1:K];
	assign q0_x5 = {1'b0, q0, 2'b00} + {3'b000, q0};
	assign rem   = {3'b000, num} - q0_x5;
	assign quot  = (rem >= FIVE) ? q0 + DW'(1) : q0;

endmodule

`default_nettype wire

// ----- hw/rtl/wpta_window.sv -----
// ----------------------------------------------------------------------------
// wpta_window
// window tick counter, peak/trough trackers and the five-window sums
// ----------------------------------------------------------------------------
`default_nettype none

module wpta_window #(
	parameter int PW = 12,
	parameter int TW = 13,
	parameter int DW = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic [PW-1:0]                  sample,
	input  wire logic [wpta_pkg::WLEN_BITS-1:0] window_length,
	output wpta_pkg::wpta_status_t              status,
	output logic      [DW-1:0]                  peak_sum,
	output logic      [DW-1:0]                  trough_sum
);
	import wpta_pkg::*;

	localparam logic [TW-1:0]        TROUGH_RST = TW'(TROUGH_INIT);
	localparam logic [WIDX_BITS-1:0] WIDX_LAST  = WIDX_BITS'(WINDOWS_SUMMED);

	logic [WLEN_BITS-1:0] tick_q;
	logic [WIDX_BITS-1:0] widx_q;
	logic [PW-1:0]        peak_q;
	logic [TW-1:0]        trough_q;
	logic [DW-1:0]        psum_q;
	logic [DW-1:0]        tsum_q;
	logic [TW-1:0]        sample_tw;

	assign sample_tw   = TW'(sample);
	assign status.close = ({1'b0, tick_q} + (WLEN_BITS+1)'(1)) >= {1'b0, window_length};
	assign status.emit  = status.close && (widx_q == WIDX_LAST);
	assign peak_sum     = psum_q;
	assign trough_sum   = tsum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			widx_q   <= '0;
			peak_q   <= '0;
			trough_q <= TROUGH_RST;
			psum_q   <= '0;
			tsum_q   <= '0;
		end else if (accept) begin
			if (!status.close) begin
				if (sample > peak_q) begin
					peak_q <= sample;
				end
				if (sample_tw < trough_q) begin
					trough_q <= sample_tw;
				end
				tick_q <= tick_q + WLEN_BITS'(1);
			end else begin
				tick_q   <= '0;
				peak_q   <= '0;
				trough_q <= TROUGH_RST;
				if (widx_q != WIDX_LAST) begin
					psum_q <= psum_q + DW'(peak_q);
					tsum_q <= tsum_q + DW'(trough_q);
					widx_q <= widx_q + WIDX_BITS'(1);
				end else begin
					widx_q <= '0;
					psum_q <= '0;
					tsum_q <= '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/windowed_peak_trough_averager.sv -----
// ----------------------------------------------------------------------------
// windowed_peak_trough_averager
// five-window average of sample peaks and troughs
// ----------------------------------------------------------------------------
// Takes one sample per cycle on the slave stream. Each window of window_length
// transactions compares all but its last sample against a running peak and
// trough; the last one only closes the window. Five windows are summed, the
// sixth is dropped and closes the run with one master-side transaction holding
// both sums divided by five. The block takes one transaction every cycle; it
// stalls the slave side only when the run-closing sample arrives while the
// previous result is still waiting. The result sits in an output register
// and the division by five is done behind it.
`default_nettype none

module windowed_peak_trough_averager #(
	parameter int SAMPLE_BITS = wpta_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [wpta_pkg::WLEN_BITS-1:0]   cfg_data,       // window_length
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,        // sample
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [31:0]                      m_tdata         // avg_peak, avg_trough
);
	import wpta_pkg::*;

	localparam int TW  = (SAMPLE_BITS > TROUGH_OUT_BITS) ? SAMPLE_BITS : TROUGH_OUT_BITS;
	localparam int DW  = TW + 3;
	localparam int OUT = PEAK_OUT_BITS + TROUGH_OUT_BITS;

	logic [WLEN_BITS-1:0] wlen_q;
	wpta_status_t         status;
	logic [DW-1:0]        peak_sum;
	logic [DW-1:0]        trough_sum;
	logic [DW-1:0]        res_peak_q;
	logic [DW-1:0]        res_trough_q;
	logic                 res_valid_q;
	logic [DW-1:0]        avg_peak;
	logic [DW-1:0]        avg_trough;
	logic                 accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = !res_valid_q || m_tready || !status.emit;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
		end else if (cfg_valid) begin
			wlen_q <= cfg_data;
		end
	end

	wpta_window #(
		.PW (SAMPLE_BITS),
		.TW (TW),
		.DW (DW)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.sample        (s_tdata[SAMPLE_BITS-1:0]),
		.window_length (wlen_q),
		.status        (status),
		.peak_sum      (peak_sum),
		.trough_sum    (trough_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && status.emit) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && status.emit) begin
			res_peak_q   <= peak_sum;
			res_trough_q <= trough_sum;
		end
	end

	wpta_div5 #(.DW(DW)) u_div_peak (
		.num  (res_peak_q),
		.quot (avg_peak)
	);

	wpta_div5 #(.DW(DW)) u_div_trough (
		.num  (res_trough_q),
		.quot (avg_trough)
	);

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {(32-OUT)'(0), avg_trough[TROUGH_OUT_BITS-1:0],
		avg_peak[PEAK_OUT_BITS-1:0]};

endmodule

`default_nettype wire

// ----- tb/windowed_peak_trough_averager_tb.sv -----
// ----------------------------------------------------------------------------
// windowed_peak_trough_averager_tb
// self-checking bench for the five-window peak/trough averager
// ----------------------------------------------------------------------------
// Drives samples on the slave stream and window lengths on the config channel.
// A behavioral tracker of window peaks, troughs and their sums predicts the
// averaged results; typed rows give their own. Each master-side transaction
// is checked against the oldest prediction. A short table of directed steps
// comes first: window length one and the largest length, lowering the length
// mid-window, sample extremes and ignored upper data bits. Random phases with
// changing window lengths follow. Both sides idle at random. At one point the
// result side holds off long enough to back up the sample stream.
// ----------------------------------------------------------------------------
module windowed_peak_trough_averager_tb;
	import wpta_pkg::*;

	localparam int SAMPLE_W     = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
	localparam int IDLE_PCT     = 31;
	localparam int HOLD_CYCLES  = 600;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int MIN_RESULTS  = 48;
	localparam int SETTLE_GAP   = 8;
	localparam int N_DIRECTED   = 28;

	typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		logic [6:0]                 pad;
		logic [TROUGH_OUT_BITS-1:0] trough;
		logic [PEAK_OUT_BITS-1:0]   peak;
	} avg_pair_t;

	typedef struct {
		row_kind_t              kind;
		logic [SAMPLE_W-1:0]    value;
		bit                     typed;
		avg_pair_t              want;
	} step_row_t;

	localparam avg_pair_t NO_AVG    = '0;
	localparam avg_pair_t EMPTY_AVG = '{pad: 7'd0, trough: 13'd4096, peak: 12'd0};
	localparam avg_pair_t FULL_AVG  = '{pad: 7'd0, trough: 13'd4095, peak: 12'd4095};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [WLEN_BITS-1:0]  cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata;    // sample
	logic                  m_tvalid;
	logic                  m_tready;
	logic [31:0]           m_tdata;    // avg_peak, avg_trough

	// tracker of the block's state
	logic [WLEN_BITS-1:0]       wlen_q;
	logic [WLEN_BITS-1:0]       tick_cnt;
	logic [WIDX_BITS-1:0]       win_cnt;
	logic [PEAK_OUT_BITS-1:0]   win_max;
	logic [TROUGH_OUT_BITS-1:0] win_min;
	logic [14:0]                max_sum;
	logic [14:0]                min_sum;

	avg_pair_t avg_q[$];
	int        errors = 0;
	int        results_seen = 0;
	int        results_due = 0;
	int        stall_cnt = 0;
	int        gap_pct = IDLE_PCT;
	bit        hold_req = 1'b0;

	step_row_t directed [N_DIRECTED] = '{
		'{ROW_CFG,    16'd1,     1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd0,     1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd4095,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'hF000,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'h0FFF,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'hFFFF,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'h0800,  1'b1, EMPTY_AVG},
		'{ROW_CFG,    16'd2,     1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd4095,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd0,     1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd4095,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd0,     1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd4095,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd0,     1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd4095,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd0,     1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd4095,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd0,     1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd0,     1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd4095,  1'b1, FULL_AVG},
		'{ROW_CFG,    16'd65535, 1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'h0123,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'hF456,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'h0ABC,  1'b0, NO_AVG},
		'{ROW_CFG,    16'd3,     1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd7,     1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd4000,  1'b0, NO_AVG},
		'{ROW_SAMPLE, 16'd5,     1'b0, NO_AVG}
	};

	windowed_peak_trough_averager dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic clear_tracker();
		wlen_q   = WLEN_RESET;
		tick_cnt = '0;
		win_cnt  = '0;
		win_max  = '0;
		win_min  = TROUGH_OUT_BITS'(TROUGH_INIT);
		max_sum  = '0;
		min_sum  = '0;
	endtask

	// one tick of the window tracker; a closing tick of the sixth window emits
	task automatic track_sample(input logic [SAMPLE_W-1:0] raw, output bit emitted,
			output avg_pair_t avg);
		logic [PEAK_OUT_BITS-1:0] s;
		s = raw[SAMPLE_BITS_DEF-1:0];
		emitted = 1'b0;
		avg = '0;
		if (wlen_q != '0 && tick_cnt < wlen_q - 16'd1) begin
			if (s > win_max)
				win_max = s;
			if ({1'b0, s} < win_min)
				win_min = {1'b0, s};
			tick_cnt = tick_cnt + 16'd1;
		end else begin
			tick_cnt = '0;
			if (win_cnt < WINDOWS_SUMMED) begin
				max_sum = max_sum + 15'(win_max);
				min_sum = min_sum + 15'(win_min);
				win_cnt = win_cnt + 3'd1;
			end else begin
				win_cnt = '0;
				avg.peak = PEAK_OUT_BITS'(max_sum / 15'(WINDOWS_SUMMED));
				avg.trough = TROUGH_OUT_BITS'(min_sum / 15'(WINDOWS_SUMMED));
				max_sum = '0;
				min_sum = '0;
				emitted = 1'b1;
			end
			win_max = '0;
			win_min = TROUGH_OUT_BITS'(TROUGH_INIT);
		end
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(15);
		if (r == 0)
			return '0;
		else if (r == 1)
			return SAMPLE_W'(4095);
		else if (r == 2)
			return SAMPLE_W'($urandom_range(65535));
		return SAMPLE_W'($urandom_range(4095));
	endfunction

	// called and returns at a falling edge
	task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input bit typed,
			input avg_pair_t want);
		bit        emitted;
		avg_pair_t avg;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= raw;
		do
			@(posedge clk);
		while (!s_tready);
		track_sample(raw, emitted, avg);
		if (emitted) begin
			avg_q.push_back(typed ? want : avg);
			results_due++;
		end
		@(negedge clk);
	endtask

	// the block is idle once every result is out and trailing samples are absorbed
	task automatic settle();
		s_tvalid <= 1'b0;
		while (avg_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_GAP) @(negedge clk);
	endtask

	task automatic write_wlen(input logic [WLEN_BITS-1:0] wlen);
		cfg_valid <= 1'b1;
		cfg_data  <= wlen;
		do
			@(posedge clk);
		while (!cfg_ready);
		wlen_q = wlen;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= gap_pct);
			end
		end
	end

	always @(posedge clk) begin
		avg_pair_t got;
		avg_pair_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				results_seen++;
				if (avg_q.size() == 0) begin
					errors++;
					$display("%0t unexpected transaction: expected none, actual %h", $time, got);
				end else begin
					want = avg_q.pop_front();
					if (got.peak !== want.peak) begin
						errors++;
						$display("%0t avg_peak: expected %0d, actual %0d",
							$time, want.peak, got.peak);
					end
					if (got.trough !== want.trough) begin
						errors++;
						$display("%0t avg_trough: expected %0d, actual %0d",
							$time, want.trough, got.trough);
					end
					if (got.pad !== want.pad) begin
						errors++;
						$display("%0t tdata padding: expected %h, actual %h",
							$time, want.pad, got.pad);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stall_cnt = 0;
			end else begin
				stall_cnt++;
				if (stall_cnt >= STALL_LIMIT) begin
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	initial begin
		int phase;
		int wl;
		int len;
		int rand_sent;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		clear_tracker();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				settle();
				write_wlen(directed[i].value);
			end else begin
				send_sample(directed[i].value, directed[i].typed, directed[i].want);
			end
		end

		phase = 0;
		rand_sent = 0;
		while (rand_sent < RANDOM_ITEMS || results_due < MIN_RESULTS) begin
			phase++;
			if (phase == 3) begin
				wl  = 3;
				len = 300;
			end else if (phase % 8 == 5) begin
				wl  = 65535;
				len = $urandom_range(10, 60);
			end else if ($urandom_range(9) == 0) begin
				wl  = $urandom_range(13, 80);
				len = wl * $urandom_range(6, 13);
			end else begin
				wl  = $urandom_range(1, 12);
				len = $urandom_range(40, 250);
			end
			settle();
			write_wlen(WLEN_BITS'(wl));
			// long result-side hold-off while samples keep coming
			if (phase == 3)
				hold_req = 1'b1;
			repeat (len) begin
				gap_pct = (rand_sent >= 700 && rand_sent < 1000) ? 0 : IDLE_PCT;
				send_sample(pick_sample(), 1'b0, NO_AVG);
				rand_sent++;
			end
		end

		s_tvalid <= 1'b0;
		while (avg_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
